// ----- rtl/core/sbs_pkg.sv -----
// Package with the shared types and codes of the signal handshake bit sender.
`timescale 1ns / 1ps

package sbs_pkg;

	// Field and counter widths.
	localparam int unsigned TickW = 16;
	localparam int unsigned RetryW = 4;
	localparam int unsigned IdW = 22;
	localparam int unsigned CfgIndexW = 3;

	// Register reset values.
	localparam logic [TickW-1:0] AckTimeoutReset = 16'd500;
	localparam logic [RetryW-1:0] RetryLimitReset = 4'd3;
	localparam logic [TickW-1:0] ConnectIntervalReset = 16'd500;
	localparam logic [TickW-1:0] IdleLimitReset = 16'd2000;
	localparam logic [TickW-1:0] ProbeWaitReset = 16'd500;
	localparam logic [IdW-1:0] PartnerIdReset = 22'd0;

	// Event codes carried by an input item.
	typedef enum logic [1:0] {
		MODE_TICK   = 2'd0,
		MODE_FIRST  = 2'd1,
		MODE_SECOND = 2'd2,
		MODE_SEND   = 2'd3
	} mode_t;

	// Link phases.
	typedef enum logic [2:0] {
		PH_CONNECTING = 3'd0,
		PH_QUEUED     = 3'd1,
		PH_READY      = 3'd2,
		PH_AWAIT      = 3'd3,
		PH_FAILED     = 3'd4
	} phase_t;

	// Configuration register indexes.
	typedef enum logic [CfgIndexW-1:0] {
		REG_ACK_TIMEOUT      = 3'd0,
		REG_RETRY_LIMIT      = 3'd1,
		REG_CONNECT_INTERVAL = 3'd2,
		REG_IDLE_LIMIT       = 3'd3,
		REG_PROBE_WAIT       = 3'd4,
		REG_PARTNER_ID       = 3'd5
	} cfg_reg_t;

	// One input item.
	typedef struct packed {
		logic [1:0] mode;
		logic       bit_value;
	} item_t;

	// One result item.
	typedef struct packed {
		logic           signal_valid;
		logic           signal_kind;
		logic [IdW-1:0] target_id;
		logic [2:0]     phase;
		logic           bit_acked;
		logic           request_refused;
	} result_t;

	// Configuration register set.
	typedef struct packed {
		logic [TickW-1:0]  ack_timeout_ticks;
		logic [RetryW-1:0] retry_limit;
		logic [TickW-1:0]  connect_interval_ticks;
		logic [TickW-1:0]  idle_limit_ticks;
		logic [TickW-1:0]  probe_wait_ticks;
		logic [IdW-1:0]    partner_id;
	} cfg_regs_t;

	// Link state kept between items.
	typedef struct packed {
		phase_t            link_phase;
		logic [TickW-1:0]  tick_count;
		logic [RetryW-1:0] send_count;
		logic              probe_pending;
		logic              held_bit;
	} link_state_t;

endpackage

// ----- rtl/core/sbs_step.sv -----
// Combinational update of the link state and result for one event.
`timescale 1ns / 1ps

module sbs_step import sbs_pkg::*; (
	input  link_state_t cur,
	input  cfg_regs_t   cfg,
	input  item_t       item,
	output link_state_t nxt,
	output result_t     result
);

	logic [TickW:0] next_cnt;
	logic           refused;
	logic           emit;
	logic           kind;
	logic           acked;

	// Tick count after this tick, one bit wider so that it never wraps.
	assign next_cnt = {1'b0, cur.tick_count} + {{TickW{1'b0}}, 1'b1};

	// A send request outside the ready phase is refused and changes nothing.
	assign refused = (mode_t'(item.mode) == MODE_SEND) && (cur.link_phase != PH_READY);

	// Next state of the link.
	always_comb begin
		nxt = cur;
		if (!refused) begin
			unique case (cur.link_phase)
				PH_CONNECTING: begin
					case (mode_t'(item.mode))
						MODE_TICK: begin
							nxt.tick_count = (next_cnt >= {1'b0, cfg.connect_interval_ticks}) ?
								'0 : next_cnt[TickW-1:0];
						end
						MODE_FIRST: begin
							nxt.link_phase = PH_QUEUED;
							nxt.tick_count = '0;
							nxt.probe_pending = 1'b0;
						end
						default: ;
					endcase
				end
				PH_QUEUED: begin
					if (mode_t'(item.mode) == MODE_TICK) begin
						if (cur.probe_pending) begin
							if (next_cnt >= {1'b0, cfg.probe_wait_ticks}) begin
								nxt.link_phase = PH_FAILED;
							end else begin
								nxt.tick_count = next_cnt[TickW-1:0];
							end
						end else if (next_cnt >= {1'b0, cfg.idle_limit_ticks}) begin
							nxt.probe_pending = 1'b1;
							nxt.tick_count = '0;
						end else begin
							nxt.tick_count = next_cnt[TickW-1:0];
						end
					end else begin
						// Any received signal shows the partner is alive.
						nxt.probe_pending = 1'b0;
						nxt.tick_count = '0;
						if (mode_t'(item.mode) == MODE_SECOND) begin
							nxt.link_phase = PH_READY;
						end
					end
				end
				PH_READY: begin
					if (mode_t'(item.mode) == MODE_SEND) begin
						nxt.held_bit = item.bit_value;
						nxt.send_count = {{(RetryW-1){1'b0}}, 1'b1};
						nxt.tick_count = '0;
						nxt.link_phase = PH_AWAIT;
					end
				end
				PH_AWAIT: begin
					case (mode_t'(item.mode))
						MODE_FIRST: begin
							nxt.tick_count = '0;
							nxt.link_phase = PH_READY;
						end
						MODE_TICK: begin
							if (next_cnt >= {1'b0, cfg.ack_timeout_ticks}) begin
								if (cur.send_count >= cfg.retry_limit) begin
									nxt.link_phase = PH_FAILED;
								end else begin
									nxt.send_count = cur.send_count + {{(RetryW-1){1'b0}}, 1'b1};
									nxt.tick_count = '0;
								end
							end else begin
								nxt.tick_count = next_cnt[TickW-1:0];
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// Signals emitted and flags raised by this event.
	always_comb begin
		emit = 1'b0;
		kind = 1'b0;
		acked = 1'b0;
		if (!refused) begin
			unique case (cur.link_phase)
				PH_CONNECTING: begin
					emit = (mode_t'(item.mode) == MODE_TICK) && (cur.tick_count == '0);
				end
				PH_QUEUED: begin
					emit = (mode_t'(item.mode) == MODE_TICK) && !cur.probe_pending &&
						(next_cnt >= {1'b0, cfg.idle_limit_ticks});
				end
				PH_READY: begin
					emit = (mode_t'(item.mode) == MODE_SEND);
					kind = item.bit_value;
				end
				PH_AWAIT: begin
					acked = (mode_t'(item.mode) == MODE_FIRST);
					emit = (mode_t'(item.mode) == MODE_TICK) &&
						(next_cnt >= {1'b0, cfg.ack_timeout_ticks}) &&
						(cur.send_count < cfg.retry_limit);
					kind = cur.held_bit;
				end
				default: ;
			endcase
		end
	end

	// Result item.
	always_comb begin
		result.signal_valid = emit;
		result.signal_kind = emit & kind;
		result.target_id = emit ? cfg.partner_id : '0;
		result.phase = nxt.link_phase;
		result.bit_acked = acked;
		result.request_refused = refused;
	end

endmodule

// ----- rtl/core/signal_handshake_bit_sender.sv -----
// Top level of the signal handshake bit sender: input stage, link state, result register.
// Items pass the input stage, then the result register; the link state update is short logic.
// Throughput: one item per cycle unless the result side stalls; the update is a single pass.
// The next item sees the state left by the one before, so the state register closes the loop.
// Reset clears both stages, puts the link in the connecting phase with zero counters,
// and loads the register reset values; the configuration port is always ready.
`timescale 1ns / 1ps

module signal_handshake_bit_sender import sbs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  item_t                item_data,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [IdW-1:0]       cfg_wdata
);

	cfg_regs_t   cfg_q;
	link_state_t state_q;
	link_state_t state_nxt;
	result_t     step_result;
	item_t       item_s1;
	logic        valid_s1;
	logic        advance;
	logic        item_take;
	result_t     result_q;
	logic        result_valid_q;

	assign cfg_ready = 1'b1;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ack_timeout_ticks <= AckTimeoutReset;
			cfg_q.retry_limit <= RetryLimitReset;
			cfg_q.connect_interval_ticks <= ConnectIntervalReset;
			cfg_q.idle_limit_ticks <= IdleLimitReset;
			cfg_q.probe_wait_ticks <= ProbeWaitReset;
			cfg_q.partner_id <= PartnerIdReset;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_ACK_TIMEOUT:      cfg_q.ack_timeout_ticks <= cfg_wdata[TickW-1:0];
				REG_RETRY_LIMIT:      cfg_q.retry_limit <= cfg_wdata[RetryW-1:0];
				REG_CONNECT_INTERVAL: cfg_q.connect_interval_ticks <= cfg_wdata[TickW-1:0];
				REG_IDLE_LIMIT:       cfg_q.idle_limit_ticks <= cfg_wdata[TickW-1:0];
				REG_PROBE_WAIT:       cfg_q.probe_wait_ticks <= cfg_wdata[TickW-1:0];
				REG_PARTNER_ID:       cfg_q.partner_id <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Handshake: the input stage moves on whenever the result register is free or drains.
	assign advance = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign item_take = item_valid && !item_stall;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= item_take || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			item_s1 <= item_data;
		end
	end

	// Link state update for the item in the input stage.
	sbs_step u_step (
		.cur    (state_q),
		.cfg    (cfg_q),
		.item   (item_s1),
		.nxt    (state_nxt),
		.result (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.link_phase <= PH_CONNECTING;
			state_q.tick_count <= '0;
			state_q.send_count <= '0;
			state_q.probe_pending <= 1'b0;
			state_q.held_bit <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= step_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data = result_q;

	// Failure holds until reset.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.link_phase == PH_FAILED |=> state_q.link_phase == PH_FAILED)
		else $error("failed phase was left without reset");

	// A refused request emits nothing and acknowledges nothing.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.request_refused |->
			!result_data.signal_valid && !result_data.bit_acked)
		else $error("refused request produced a signal or an ack");

	// An acknowledged bit always returns the link to the ready phase.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.bit_acked |-> result_data.phase == PH_READY)
		else $error("ack without return to ready");

	// The state changes only when an item moves into the result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("link state changed without an item");

endmodule

// ----- tb/signal_handshake_bit_sender_tb.sv -----
// Self-checking testbench for the signal handshake bit sender, with its own link predictor.
`timescale 1ns / 1ps

module signal_handshake_bit_sender_tb;
	import sbs_pkg::*;

	// Predicts the link state and the result of every transfer, and checks the results.
	class link_tracker;
		cfg_regs_t   regs;
		phase_t      ph;
		logic [TickW-1:0]  ticks;
		logic [RetryW-1:0] sends;
		logic        probe;
		logic        held;
		result_t     due_results[$];
		int unsigned errors;

		function new();
			regs.ack_timeout_ticks = AckTimeoutReset;
			regs.retry_limit = RetryLimitReset;
			regs.connect_interval_ticks = ConnectIntervalReset;
			regs.idle_limit_ticks = IdleLimitReset;
			regs.probe_wait_ticks = ProbeWaitReset;
			regs.partner_id = PartnerIdReset;
			ph = PH_CONNECTING;
			ticks = '0;
			sends = '0;
			probe = 1'b0;
			held = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [IdW-1:0] v);
			case (idx)
				REG_ACK_TIMEOUT:      regs.ack_timeout_ticks = v[TickW-1:0];
				REG_RETRY_LIMIT:      regs.retry_limit = v[RetryW-1:0];
				REG_CONNECT_INTERVAL: regs.connect_interval_ticks = v[TickW-1:0];
				REG_IDLE_LIMIT:       regs.idle_limit_ticks = v[TickW-1:0];
				REG_PROBE_WAIT:       regs.probe_wait_ticks = v[TickW-1:0];
				REG_PARTNER_ID:       regs.partner_id = v;
				default: ;
			endcase
		endfunction

		// A tick now would end the link through an unanswered probe.
		function bit probe_expires();
			return ph == PH_QUEUED && probe && (ticks + 32'd1 >= regs.probe_wait_ticks);
		endfunction

		// A tick now would end the link through the last retry running out.
		function bit retries_exhausted();
			return ph == PH_AWAIT && (ticks + 32'd1 >= regs.ack_timeout_ticks)
				&& (sends >= regs.retry_limit);
		endfunction

		function int unsigned outstanding();
			return due_results.size();
		endfunction

		// Advances the link by one accepted event and queues the result it causes.
		function void note_event(item_t it);
			result_t     r;
			int unsigned next;
			logic        emit;
			logic        kind;
			r = '0;
			emit = 1'b0;
			kind = 1'b0;
			next = ticks + 32'd1;
			if (it.mode == MODE_SEND && ph != PH_READY) begin
				r.request_refused = 1'b1;
			end else begin
				case (ph)
					PH_CONNECTING: begin
						if (it.mode == MODE_TICK) begin
							emit = (ticks == '0);
							ticks = (next >= regs.connect_interval_ticks) ? '0 : next[TickW-1:0];
						end else if (it.mode == MODE_FIRST) begin
							ph = PH_QUEUED;
							ticks = '0;
							probe = 1'b0;
						end
					end
					PH_QUEUED: begin
						if (it.mode == MODE_TICK) begin
							if (probe) begin
								if (next >= regs.probe_wait_ticks)
									ph = PH_FAILED;
								else
									ticks = next[TickW-1:0];
							end else if (next >= regs.idle_limit_ticks) begin
								emit = 1'b1;
								probe = 1'b1;
								ticks = '0;
							end else begin
								ticks = next[TickW-1:0];
							end
						end else begin
							// Any received signal shows the partner is alive.
							probe = 1'b0;
							ticks = '0;
							if (it.mode == MODE_SECOND)
								ph = PH_READY;
						end
					end
					PH_READY: begin
						if (it.mode == MODE_SEND) begin
							held = it.bit_value;
							emit = 1'b1;
							kind = it.bit_value;
							sends = RetryW'(1);
							ticks = '0;
							ph = PH_AWAIT;
						end
					end
					PH_AWAIT: begin
						if (it.mode == MODE_FIRST) begin
							r.bit_acked = 1'b1;
							ticks = '0;
							ph = PH_READY;
						end else if (it.mode == MODE_TICK) begin
							if (next >= regs.ack_timeout_ticks) begin
								if (sends >= regs.retry_limit) begin
									ph = PH_FAILED;
								end else begin
									emit = 1'b1;
									kind = held;
									sends = sends + 1'b1;
									ticks = '0;
								end
							end else begin
								ticks = next[TickW-1:0];
							end
						end
					end
					default: ;
				endcase
			end
			r.signal_valid = emit;
			r.signal_kind = emit ? kind : 1'b0;
			r.target_id = emit ? regs.partner_id : '0;
			r.phase = ph;
			due_results.push_back(r);
		endfunction

		function void report(string what, result_t exp, result_t got);
			errors++;
			if (errors <= 10)
				$display("%0t: %s: expected valid=%0d kind=%0d id=%h phase=%0d acked=%0d refused=%0d, got valid=%0d kind=%0d id=%h phase=%0d acked=%0d refused=%0d",
					$realtime, what,
					exp.signal_valid, exp.signal_kind, exp.target_id, exp.phase,
					exp.bit_acked, exp.request_refused,
					got.signal_valid, got.signal_kind, got.target_id, got.phase,
					got.bit_acked, got.request_refused);
		endfunction

		// Compares one result transfer with the oldest prediction.
		function void check_result(result_t got);
			result_t exp;
			if (due_results.size() == 0) begin
				report("result with nothing pending", '0, got);
				return;
			end
			exp = due_results.pop_front();
			if (got.signal_valid !== exp.signal_valid || got.signal_kind !== exp.signal_kind
				|| got.target_id !== exp.target_id || got.phase !== exp.phase
				|| got.bit_acked !== exp.bit_acked
				|| got.request_refused !== exp.request_refused)
				report("result mismatch", exp, got);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	item_t                item_data = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CfgIndexW-1:0] cfg_index = '0;
	logic [IdW-1:0]       cfg_wdata = '0;

	link_tracker tracker = new();
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned profile = 0;

	signal_handshake_bit_sender i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item_data    (item_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// Receiver side: random stall, and every result transfer is checked.
	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			tracker.check_result(result_data);
	end

	// Presents one event and waits for its transfer.
	task automatic send_item(input mode_t m, input logic b);
		item_t it;
		it.mode = m;
		it.bit_value = b;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item_data <= it;
		do @(posedge clk); while (item_stall);
		tracker.note_event(it);
	endtask

	// Picks an event suited to the current phase; never lets the link fail by accident.
	task automatic send_random();
		int unsigned r;
		mode_t       m;
		r = $urandom_range(99);
		case (tracker.ph)
			PH_CONNECTING: m = (r < 70) ? MODE_TICK : (r < 85) ? MODE_SECOND : MODE_SEND;
			PH_QUEUED: begin
				m = (r < 70) ? MODE_TICK : (r < 88) ? MODE_FIRST : MODE_SEND;
				if (m == MODE_TICK && tracker.probe_expires())
					m = MODE_FIRST;
			end
			PH_READY: m = (r < 70) ? MODE_SEND : (r < 85) ? MODE_TICK :
				(r < 93) ? MODE_FIRST : MODE_SECOND;
			PH_AWAIT: begin
				m = (r < 55) ? MODE_TICK : (r < 80) ? MODE_FIRST :
					(r < 90) ? MODE_SECOND : MODE_SEND;
				if (m == MODE_TICK && tracker.retries_exhausted())
					m = MODE_FIRST;
			end
			default: m = mode_t'($urandom_range(3));
		endcase
		send_item(m, 1'($urandom_range(1)));
	endtask

	// Stops sending until every predicted result has arrived, then lets the pipeline empty.
	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int unsigned v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v[IdW-1:0];
		do @(posedge clk); while (!cfg_ready);
		tracker.write_reg(idx, v[IdW-1:0]);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Writes a full register set while the block is idle and moves to the next idling profile.
	task automatic reconfigure(input int unsigned ack, input int unsigned retry,
			input int unsigned conn, input int unsigned idle, input int unsigned probe_wait,
			input int unsigned partner);
		drain();
		write_reg(REG_ACK_TIMEOUT, ack);
		write_reg(REG_RETRY_LIMIT, retry);
		write_reg(REG_CONNECT_INTERVAL, conn);
		write_reg(REG_IDLE_LIMIT, idle);
		write_reg(REG_PROBE_WAIT, probe_wait);
		write_reg(REG_PARTNER_ID, partner);
		case (profile % 4)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 76; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 76; end
			default: begin idle_pct = 36; stall_pct = 36; end
		endcase
		profile++;
	endtask

	// Main sequence: connecting, queued, bit transfers, and the failed link at the end.
	initial begin
		int unsigned conn_set[6] = '{1, 0, 3, 65535, 7, 2};
		int unsigned idle_set[7] = '{0, 1, 2, 5, 65535, 3, 65535};
		int unsigned probe_set[7] = '{0, 1, 3, 4, 65535, 65535, 1};
		int unsigned ack_set[8] = '{1, 0, 2, 4, 65535, 3, 1, 6};
		int unsigned retry_set[8] = '{1, 2, 3, 15, 15, 5, 15, 2};
		int unsigned partner;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset register values: refused requests, an ignored second signal,
		// and the first tick sending a connection request at once.
		send_item(MODE_SEND, 1'b0);
		send_item(MODE_SEND, 1'b1);
		send_item(MODE_SECOND, 1'b1);
		send_item(MODE_TICK, 1'b1);
		send_item(MODE_TICK, 1'b0);
		send_item(MODE_SEND, 1'b1);
		send_item(MODE_TICK, 1'b0);

		// Connecting: connection requests under several intervals, with ignored
		// second signals and refused requests; a first signal then enters queued.
		for (int i = 0; i < 6; i++) begin
			partner = (i == 0) ? 32'h3F_FFFF : (i == 1) ? 0 : $urandom_range(32'h3F_FFFF);
			reconfigure($urandom_range(1, 8), $urandom_range(1, 15), conn_set[i],
				$urandom_range(1, 6), $urandom_range(1, 6), partner);
			repeat (40) send_random();
		end
		if (tracker.ph == PH_CONNECTING)
			send_item(MODE_FIRST, 1'($urandom_range(1)));

		// Queued: idle probes, replies and refused requests.
		for (int i = 0; i < 7; i++) begin
			reconfigure($urandom_range(1, 8), $urandom_range(1, 15), $urandom_range(1, 6),
				idle_set[i], probe_set[i], $urandom_range(32'h3F_FFFF));
			repeat (50) send_random();
		end
		send_item(MODE_SECOND, 1'($urandom_range(1)));

		// Bit transfers with acknowledgements, timeouts and resends.
		for (int i = 0; i < 8; i++) begin
			reconfigure(ack_set[i], retry_set[i], $urandom_range(1, 6), $urandom_range(1, 6),
				$urandom_range(1, 6), $urandom_range(32'h3F_FFFF));
			repeat (160) send_random();
		end

		// Let the retries run out, sometimes with a zero retry limit, then poke the dead link.
		reconfigure($urandom_range(1, 3), $urandom_range(1) ? 0 : $urandom_range(1, 3),
			$urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6),
			$urandom_range(32'h3F_FFFF));
		while (tracker.ph != PH_FAILED) begin
			if (tracker.ph == PH_READY)
				send_item(MODE_SEND, 1'($urandom_range(1)));
			else
				send_item(MODE_TICK, 1'($urandom_range(1)));
		end
		repeat (40) send_random();

		drain();
		if (tracker.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/sbs_pkg.sv
rtl/core/sbs_step.sv
rtl/core/signal_handshake_bit_sender.sv
tb/signal_handshake_bit_sender_tb.sv
